// ===== src/rcz_pkg.sv =====
// Shared types, constants and helpers for the RGB 3x3 zero-pad convolution block.
`timescale 1ns / 1ps

package rcz_pkg;

  // Frame limits
  localparam int MAX_WIDTH      = 1024;
  localparam int MAX_HEIGHT     = 4096;
  localparam int COEF_FRAC_BITS = 8;

  // Field widths
  localparam int COL_W    = 10;
  localparam int ROW_W    = 12;
  localparam int FW_W     = 11;
  localparam int FH_W     = 13;
  localparam int PEND_W   = 11;
  localparam int FLUSH_W  = 12;
  localparam int CHAN_W   = 8;
  localparam int PIX_W    = 3 * CHAN_W;
  localparam int COEF_W   = 16;
  localparam int KROW_W   = 3 * COEF_W;
  localparam int MEM_AW   = $clog2(MAX_WIDTH);

  // Arithmetic widths: unsigned 8 bit pixel (9 bit signed) times 16 bit coefficient
  localparam int PROD_W   = CHAN_W + 1 + COEF_W;
  localparam int ROWSUM_W = PROD_W + 2;
  localparam int SUM_W    = ROWSUM_W + 2;
  localparam int CHAN_MAX = (1 << CHAN_W) - 1;

  // Output queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Request codes
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  // Configuration register indexes (byte address = 8 * index)
  localparam int APB_AW = 6;
  localparam logic [2:0] REG_FRAME_WIDTH   = 3'd0;
  localparam logic [2:0] REG_FRAME_HEIGHT  = 3'd1;
  localparam logic [2:0] REG_KERNEL_TOP    = 3'd2;
  localparam logic [2:0] REG_KERNEL_MID    = 3'd3;
  localparam logic [2:0] REG_KERNEL_BOTTOM = 3'd4;

  // Reset values: identity kernel
  localparam logic [FW_W-1:0]   FRAME_WIDTH_RST  = FW_W'(1024);
  localparam logic [FH_W-1:0]   FRAME_HEIGHT_RST = FH_W'(1024);
  localparam logic [KROW_W-1:0] KERNEL_TOP_RST   = '0;
  localparam logic [KROW_W-1:0] KERNEL_MID_RST   = KROW_W'(48'h0000_0100_0000);
  localparam logic [KROW_W-1:0] KERNEL_BOT_RST   = '0;

  typedef logic [PIX_W-1:0] pixel_t;           // r 7:0, g 15:8, b 23:16
  typedef logic [8:0][PIX_W-1:0] window_t;     // row*3 + col, col 0 oldest
  typedef logic [2:0][KROW_W-1:0] kernel_t;    // row 0 is top

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             last;
    logic             top_ok;
    logic             bot_ok;
    logic             left_ok;
    logic             right_ok;
  } meta_t;

  typedef struct packed {
    logic [CHAN_W-1:0] r;
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] b;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic              last;
  } result_t;

endpackage

// ===== src/rcz_mac.sv =====
// Three-stage multiply, row-sum and total/clamp pipeline for the 3x3 window.
`timescale 1ns / 1ps

module rcz_mac (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  rcz_pkg::meta_t   meta,
  input  rcz_pkg::window_t window,
  input  rcz_pkg::kernel_t kernel,
  output logic             res_valid,
  output rcz_pkg::result_t res
);

  localparam int QW = rcz_pkg::SUM_W - 1 - rcz_pkg::COEF_FRAC_BITS;

  logic signed [rcz_pkg::PROD_W-1:0]   prod_c [3][9];
  logic signed [rcz_pkg::PROD_W-1:0]   prod_a [3][9];
  logic signed [rcz_pkg::ROWSUM_W-1:0] row_b  [3][3];
  logic signed [rcz_pkg::SUM_W-1:0]    sum_c  [3];
  logic [2:0][rcz_pkg::CHAN_W-1:0]     chan_c;
  logic [2:0]                          row_en;
  logic [2:0]                          col_en;
  logic                                va, vb;
  rcz_pkg::meta_t                      meta_a, meta_b;

  assign row_en = {meta.bot_ok, 1'b1, meta.top_ok};
  assign col_en = {meta.right_ok, 1'b1, meta.left_ok};

  // Stage A operands: masked products, padding contributes zero
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          if (row_en[i] && col_en[j]) begin
            prod_c[ch][i*3+j] =
              $signed({1'b0, window[i*3+j][rcz_pkg::CHAN_W*ch +: rcz_pkg::CHAN_W]}) *
              $signed(kernel[i][rcz_pkg::COEF_W*j +: rcz_pkg::COEF_W]);
          end else begin
            prod_c[ch][i*3+j] = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_a <= prod_c;
    meta_a <= meta;
    for (int ch = 0; ch < 3; ch++) begin
      for (int i = 0; i < 3; i++) begin
        row_b[ch][i] <= rcz_pkg::ROWSUM_W'(prod_a[ch][i*3])
                      + rcz_pkg::ROWSUM_W'(prod_a[ch][i*3+1])
                      + rcz_pkg::ROWSUM_W'(prod_a[ch][i*3+2]);
      end
    end
    meta_b <= meta_a;
  end

  // Stage C: total, drop fraction, clamp to 0..255
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum_c[ch] = rcz_pkg::SUM_W'(row_b[ch][0]) + rcz_pkg::SUM_W'(row_b[ch][1])
                + rcz_pkg::SUM_W'(row_b[ch][2]);
      if (sum_c[ch][rcz_pkg::SUM_W-1]) begin
        chan_c[ch] = '0;
      end else if (sum_c[ch][rcz_pkg::SUM_W-2:rcz_pkg::COEF_FRAC_BITS] >
                   QW'(rcz_pkg::CHAN_MAX)) begin
        chan_c[ch] = rcz_pkg::CHAN_W'(rcz_pkg::CHAN_MAX);
      end else begin
        chan_c[ch] = sum_c[ch][rcz_pkg::COEF_FRAC_BITS +: rcz_pkg::CHAN_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    res.r    <= chan_c[0];
    res.g    <= chan_c[1];
    res.b    <= chan_c[2];
    res.col  <= meta_b.col;
    res.row  <= meta_b.row;
    res.last <= meta_b.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      va        <= start;
      vb        <= va;
      res_valid <= vb;
    end
  end

endmodule

// ===== src/rcz_fifo.sv =====
// Small output queue that holds finished results until the consumer takes them.
`timescale 1ns / 1ps

module rcz_fifo (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  rcz_pkg::result_t          din,
  input  logic                      pop_ready,
  output logic                      valid,
  output rcz_pkg::result_t          dout,
  output logic [rcz_pkg::FIFO_AW:0] count
);

  rcz_pkg::result_t             mem [rcz_pkg::FIFO_DEPTH];
  logic [rcz_pkg::FIFO_AW-1:0]  wr_ptr, rd_ptr;
  logic                         pop;

  assign valid = (count != '0);
  assign pop   = valid && pop_ready;
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== src/rgb_conv3x3_zero_pad_top.sv =====
// Top level of the streaming RGB 3x3 convolution with zero padding.
`timescale 1ns / 1ps

// Streaming 3x3 convolution of RGB pixels in raster order, with zero padding at the
// frame edges. One transaction per clock is sustained on the input in steady state.
// The result for a pixel leaves width+1 pixel transactions after that pixel entered;
// flush transactions (req_type 1) after the frame's last pixel push out the pending
// results, one per flush. Once the transaction that causes a result is accepted, the
// result passes through the synchronous line store read, the window shift, then the
// multiply, row sum and total/clamp stages before it reaches the output queue. The output
// queue holds 8 results; in_ready drops only when queued plus in-flight results fill it,
// so a stalled consumer does not block the input until then. Line stores are not cleared
// after reset: only padded, masked taps can see a never-written entry. Coefficients are
// signed Q7.8; each channel sum is truncated and clamped to 0..255. Register map (64-bit
// APB data, byte address 8*index): 0 frame_width, 1 frame_height, 2..4 kernel rows top,
// middle, bottom (left coefficient in bits 15:0). Configuration is to be written only
// while the block is idle.

module rgb_conv3x3_zero_pad_top (
  input  logic                         clk,
  input  logic                         rst,
  // input channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         req_type,
  input  logic [rcz_pkg::CHAN_W-1:0]   pix_r,
  input  logic [rcz_pkg::CHAN_W-1:0]   pix_g,
  input  logic [rcz_pkg::CHAN_W-1:0]   pix_b,
  // output channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rcz_pkg::CHAN_W-1:0]   out_r,
  output logic [rcz_pkg::CHAN_W-1:0]   out_g,
  output logic [rcz_pkg::CHAN_W-1:0]   out_b,
  output logic [rcz_pkg::COL_W-1:0]    out_col,
  output logic [rcz_pkg::ROW_W-1:0]    out_row,
  output logic                         frame_last,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rcz_pkg::APB_AW-1:0]   paddr,
  input  logic [63:0]                  pwdata,
  output logic [63:0]                  prdata,
  output logic                         pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [rcz_pkg::FW_W-1:0]   frame_width;
  logic [rcz_pkg::FH_W-1:0]   frame_height;
  logic [rcz_pkg::KROW_W-1:0] kernel_top_row, kernel_mid_row, kernel_bottom_row;
  logic [2:0]                 reg_index;
  logic                       cfg_write;

  assign pready    = 1'b1;
  assign reg_index = paddr[5:3];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width       <= rcz_pkg::FRAME_WIDTH_RST;
      frame_height      <= rcz_pkg::FRAME_HEIGHT_RST;
      kernel_top_row    <= rcz_pkg::KERNEL_TOP_RST;
      kernel_mid_row    <= rcz_pkg::KERNEL_MID_RST;
      kernel_bottom_row <= rcz_pkg::KERNEL_BOT_RST;
    end else if (cfg_write) begin
      case (reg_index)
        rcz_pkg::REG_FRAME_WIDTH:   frame_width       <= pwdata[rcz_pkg::FW_W-1:0];
        rcz_pkg::REG_FRAME_HEIGHT:  frame_height      <= pwdata[rcz_pkg::FH_W-1:0];
        rcz_pkg::REG_KERNEL_TOP:    kernel_top_row    <= pwdata[rcz_pkg::KROW_W-1:0];
        rcz_pkg::REG_KERNEL_MID:    kernel_mid_row    <= pwdata[rcz_pkg::KROW_W-1:0];
        rcz_pkg::REG_KERNEL_BOTTOM: kernel_bottom_row <= pwdata[rcz_pkg::KROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      rcz_pkg::REG_FRAME_WIDTH:   prdata = 64'(frame_width);
      rcz_pkg::REG_FRAME_HEIGHT:  prdata = 64'(frame_height);
      rcz_pkg::REG_KERNEL_TOP:    prdata = 64'(kernel_top_row);
      rcz_pkg::REG_KERNEL_MID:    prdata = 64'(kernel_mid_row);
      rcz_pkg::REG_KERNEL_BOTTOM: prdata = 64'(kernel_bottom_row);
      default:                    prdata = '0;
    endcase
  end

  // Effective frame size: zero acts as one, oversize saturates
  logic [rcz_pkg::FW_W-1:0] w_eff;
  logic [rcz_pkg::FH_W-1:0] h_eff;
  logic [rcz_pkg::FW_W:0]   w_plus1;

  assign w_eff = (frame_width == '0) ? rcz_pkg::FW_W'(1) :
                 (frame_width > rcz_pkg::FW_W'(rcz_pkg::MAX_WIDTH)) ?
                   rcz_pkg::FW_W'(rcz_pkg::MAX_WIDTH) : frame_width;
  assign h_eff = (frame_height == '0) ? rcz_pkg::FH_W'(1) :
                 (frame_height > rcz_pkg::FH_W'(rcz_pkg::MAX_HEIGHT)) ?
                   rcz_pkg::FH_W'(rcz_pkg::MAX_HEIGHT) : frame_height;
  assign w_plus1 = {1'b0, w_eff} + 1'b1;

  // ---------------------------------------------------------------------------
  // Position and pending bookkeeping, decided at accept time
  // ---------------------------------------------------------------------------
  logic [rcz_pkg::COL_W-1:0]   in_column, in_column_next;
  logic [rcz_pkg::ROW_W-1:0]   in_row, in_row_next;
  logic [rcz_pkg::COL_W-1:0]   emit_column, emit_column_next;
  logic [rcz_pkg::ROW_W-1:0]   emit_row, emit_row_next;
  logic [rcz_pkg::PEND_W-1:0]  pending_count, pending_count_next;
  logic [rcz_pkg::FLUSH_W-1:0] flush_shifts, flush_shifts_next;

  logic                        acc, is_flush, restart, take, prod;
  logic [rcz_pkg::COL_W-1:0]   base_col, base_ec;
  logic [rcz_pkg::ROW_W-1:0]   base_row, base_er;
  logic [rcz_pkg::PEND_W-1:0]  base_pend;
  logic [rcz_pkg::PEND_W:0]    pend_inc;
  logic [rcz_pkg::FLUSH_W-1:0] fs_inc;
  logic [rcz_pkg::FLUSH_W:0]   pend_sum;
  logic                        col_wrap, row_wrap, ec_wrap, er_wrap;
  rcz_pkg::meta_t              prod_meta;

  assign acc      = in_valid && in_ready;
  assign is_flush = (req_type == rcz_pkg::REQ_FLUSH);
  // a pixel after a flush starts a fresh frame
  assign restart  = !is_flush && (flush_shifts != '0);

  assign base_col  = restart ? '0 : in_column;
  assign base_row  = restart ? '0 : in_row;
  assign base_ec   = restart ? '0 : emit_column;
  assign base_er   = restart ? '0 : emit_row;
  assign base_pend = restart ? '0 : pending_count;

  assign pend_inc = {1'b0, base_pend} + 1'b1;
  assign fs_inc   = flush_shifts + 1'b1;
  assign pend_sum = rcz_pkg::FLUSH_W'(pending_count) + {1'b0, flush_shifts} + 1'b1;

  assign col_wrap = ({1'b0, base_col} + 1'b1) >= w_eff;
  assign row_wrap = ({1'b0, base_row} + 1'b1) >= h_eff;
  assign ec_wrap  = ({1'b0, base_ec} + 1'b1) >= w_eff;
  assign er_wrap  = ({1'b0, base_er} + 1'b1) >= h_eff;

  always_comb begin
    in_column_next     = in_column;
    in_row_next        = in_row;
    emit_column_next   = emit_column;
    emit_row_next      = emit_row;
    pending_count_next = pending_count;
    flush_shifts_next  = flush_shifts;
    take               = 1'b0;
    prod               = 1'b0;
    if (acc) begin
      if (!is_flush) begin
        take              = 1'b1;
        flush_shifts_next = '0;
        emit_column_next  = base_ec;
        emit_row_next     = base_er;
        if (col_wrap) begin
          in_column_next = '0;
          in_row_next    = row_wrap ? '0 : base_row + 1'b1;
        end else begin
          in_column_next = base_col + 1'b1;
          in_row_next    = base_row;
        end
        if (pend_inc > {1'b0, w_plus1}) begin
          prod               = 1'b1;
          pending_count_next = base_pend;
        end else begin
          pending_count_next = pend_inc[rcz_pkg::PEND_W-1:0];
        end
      end else if (pending_count != '0 &&
                   !(flush_shifts == '0 && (in_column != '0 || in_row != '0))) begin
        // flush: advance the window with an empty bottom row, no store write
        take              = 1'b1;
        in_column_next    = col_wrap ? '0 : in_column + 1'b1;
        flush_shifts_next = fs_inc;
        if (pend_sum > rcz_pkg::FLUSH_W'(w_plus1) + 1'b0) begin
          prod               = 1'b1;
          pending_count_next = pending_count - 1'b1;
        end
      end
      if (prod) begin
        emit_column_next = ec_wrap ? '0 : base_ec + 1'b1;
        emit_row_next    = ec_wrap ? (er_wrap ? '0 : base_er + 1'b1) : base_er;
      end
    end
  end

  assign prod_meta.col      = base_ec;
  assign prod_meta.row      = base_er;
  assign prod_meta.last     = ec_wrap && er_wrap;
  assign prod_meta.top_ok   = (base_er != '0);
  assign prod_meta.bot_ok   = !er_wrap;
  assign prod_meta.left_ok  = (base_ec != '0);
  assign prod_meta.right_ok = !ec_wrap;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column     <= '0;
      in_row        <= '0;
      emit_column   <= '0;
      emit_row      <= '0;
      pending_count <= '0;
      flush_shifts  <= '0;
    end else begin
      in_column     <= in_column_next;
      in_row        <= in_row_next;
      emit_column   <= emit_column_next;
      emit_row      <= emit_row_next;
      pending_count <= pending_count_next;
      flush_shifts  <= flush_shifts_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Line stores: read at accept, write back in the cycle after.
  // Same-column back-to-back accesses (one-pixel-wide frames) use the bypass.
  // ---------------------------------------------------------------------------
  rcz_pkg::pixel_t line_store_upper  [rcz_pkg::MAX_WIDTH];
  rcz_pkg::pixel_t line_store_middle [rcz_pkg::MAX_WIDTH];

  logic                         s1_valid, s1_prod, s1_flush;
  logic [rcz_pkg::MEM_AW-1:0]   s1_idx;
  rcz_pkg::pixel_t              s1_pix;
  rcz_pkg::meta_t               s1_meta;
  rcz_pkg::pixel_t              up_rd, mid_rd, fwd_up, fwd_mid, up_eff, mid_eff;
  logic                         fwd;
  logic [rcz_pkg::MEM_AW-1:0]   rd_idx;
  logic                         s1_write;

  assign rd_idx   = base_col[rcz_pkg::MEM_AW-1:0];
  assign s1_write = s1_valid && !s1_flush;
  assign up_eff   = fwd ? fwd_up  : up_rd;
  assign mid_eff  = fwd ? fwd_mid : mid_rd;

  always_ff @(posedge clk) begin
    if (take) begin
      up_rd   <= line_store_upper[rd_idx];
      mid_rd  <= line_store_middle[rd_idx];
      fwd     <= s1_write && (s1_idx == rd_idx);
      fwd_up  <= mid_eff;
      fwd_mid <= s1_pix;
    end
    if (s1_write) begin
      line_store_upper[s1_idx]  <= mid_eff;
      line_store_middle[s1_idx] <= s1_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_flush <= is_flush;
      s1_idx   <= rd_idx;
      s1_pix   <= {pix_b, pix_g, pix_r};
      s1_meta  <= prod_meta;
    end
  end

  // ---------------------------------------------------------------------------
  // 3x3 window: shift in the column (upper, middle, new pixel or zero on flush)
  // ---------------------------------------------------------------------------
  rcz_pkg::window_t window_regs;
  rcz_pkg::pixel_t  new_col [3];
  logic             s2_valid;
  rcz_pkg::meta_t   s2_meta;

  assign new_col[0] = up_eff;
  assign new_col[1] = mid_eff;
  assign new_col[2] = s1_flush ? '0 : s1_pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_regs <= '0;
    end else if (s1_valid) begin
      for (int i = 0; i < 3; i++) begin
        window_regs[i*3]   <= window_regs[i*3+1];
        window_regs[i*3+1] <= window_regs[i*3+2];
        window_regs[i*3+2] <= new_col[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    s2_meta <= s1_meta;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_prod  <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= take;
      s1_prod  <= take && prod;
      s2_valid <= s1_prod;
    end
  end

  // ---------------------------------------------------------------------------
  // Arithmetic pipeline and output queue
  // ---------------------------------------------------------------------------
  rcz_pkg::kernel_t            kernel;
  logic                        res_valid;
  rcz_pkg::result_t            res, q_data;
  logic [rcz_pkg::FIFO_AW:0]   fifo_count;
  logic [rcz_pkg::FIFO_AW:0]   inflight;

  assign kernel = {kernel_bottom_row, kernel_mid_row, kernel_top_row};

  rcz_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .start     (s2_valid),
    .meta      (s2_meta),
    .window    (window_regs),
    .kernel    (kernel),
    .res_valid (res_valid),
    .res       (res)
  );

  rcz_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .din       (res),
    .pop_ready (out_ready),
    .valid     (out_valid),
    .dout      (q_data),
    .count     (fifo_count)
  );

  // credit: every in-flight result has a reserved queue slot
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else if ((acc && prod) && !res_valid) begin
      inflight <= inflight + 1'b1;
    end else if (!(acc && prod) && res_valid) begin
      inflight <= inflight - 1'b1;
    end
  end

  assign in_ready = (({1'b0, fifo_count} + {1'b0, inflight}) <
                     (rcz_pkg::FIFO_AW + 2)'(rcz_pkg::FIFO_DEPTH));

  assign out_r      = q_data.r;
  assign out_g      = q_data.g;
  assign out_b      = q_data.b;
  assign out_col    = q_data.col;
  assign out_row    = q_data.row;
  assign frame_last = q_data.last;

`ifndef NO_ASSERTIONS
  // a producing transaction lands in the queue after the fixed pipeline latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (acc && prod) |-> ##5 res_valid)
    else $error("result did not arrive after pipeline latency");

  // credit scheme never lets the queue overflow
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (fifo_count < (rcz_pkg::FIFO_AW + 1)'(rcz_pkg::FIFO_DEPTH)) ||
                  (out_valid && out_ready))
    else $error("output queue overflow");

  // the window stage only runs for a transaction taken the cycle before
  a_s1_source: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> $past(acc && take))
    else $error("window shift without an accepted transaction");
`endif

endmodule
